/* design/isct_pkg.sv */
package isct_pkg;
	localparam int MAX_INTERVALS = 16;
	localparam int IW = $clog2(MAX_INTERVALS);
	localparam int CW = $clog2(MAX_INTERVALS + 1);

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_COV  = 2'd1;
	localparam logic [1:0] OP_NEXT = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;

	localparam logic [1:0] KIND_PIECE  = 2'd0;
	localparam logic [1:0] KIND_NONE   = 2'd1;
	localparam logic [1:0] KIND_ANSWER = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	typedef struct packed {
		logic [31:0] b;
		logic [31:0] t;
	} entry_t;

	typedef struct packed {
		logic        we;
		logic [IW-1:0] waddr;
		entry_t      wdata;
		logic [IW-1:0] raddr;
	} ram_ctl_t;
endpackage

/* design/interval_set_coverage_tracker_top.sv */
// Interval set coverage tracker.
// A query scans the n stored entries once; an add that is stored scans them, then makes an emit
// pass for its pieces and a table rewrite over the single read port. Output stalls hold either.
// Throughput: one request at a time; a new request is taken only when idle with the output free.
// Reset: asynchronous, clears the entry count and control; table contents undefined.
module interval_set_coverage_tracker_top import isct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] range_start,
	input  logic [31:0] range_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [31:0] piece_start,
	output logic [31:0] piece_length,
	output logic        covered,
	output logic [31:0] next_position,
	output logic        last
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SCAN  = 4'd1; // pass 1: run, gaps, query answers
	localparam logic [3:0] ST_DEC   = 4'd2;
	localparam logic [3:0] ST_EMIT  = 4'd3; // pass 2: pieces
	localparam logic [3:0] ST_TAIL  = 4'd4;
	localparam logic [3:0] ST_WAIT  = 4'd5; // single result waiting
	localparam logic [3:0] ST_SHIFT = 4'd6; // pass 3: rewrite table
	localparam logic [3:0] ST_PUT   = 4'd7;

	logic [3:0]    state_q;
	logic [CW-1:0] n_q;
	logic [1:0]    op_q;
	logic [31:0]   s_q;
	logic [32:0]   e_q;
	logic [CW-1:0] ri_q;   // read address issued
	logic          rv_q;   // read data valid on rdata
	logic [CW-1:0] di_q;   // index of data on rdata
	logic [CW-1:0] lo_q, hi_q, k_q;
	logic [CW:0]   pieces_q, p_q;
	logic [32:0]   cur_q;
	logic          brk_q, cov_q;
	logic [31:0]   nxt_q;
	logic [31:0]   nb_q, nt_q;
	logic [CW-1:0] pos_q;
	logic          fpos_q;
	logic [CW-1:0] wi_q;   // rewrite write index
	entry_t        rdata;
	ram_ctl_t      ctl;

	logic          ov_q;
	logic [1:0]    kind_q;
	logic [31:0]   ps_q, pl_q, np_q;
	logic          cv_q, last_q;

	isct_ram u_ram (.clk(clk), .ctl(ctl), .rdata(rdata));

	wire out_free = !ov_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	wire acc = in_valid && in_ready;
	wire [32:0] e_in = {1'b0, range_start} + {1'b0, range_length};

	wire [32:0] rb = {1'b0, rdata.b};
	wire [32:0] rt = {1'b0, rdata.t};
	wire [CW-1:0] n_eff = n_q;
	wire [CW:0] newn = {1'b0, n_q} - {1'b0, k_q} + 1'b1;

	// read address and rewrite port; an entry held in the emit pass is read again
	always_comb begin
		ctl = '0;
		ctl.raddr = (state_q == ST_EMIT && rv_q) ? di_q[IW-1:0] : ri_q[IW-1:0];
		if (state_q == ST_PUT) begin
			ctl.we = 1'b1;
			ctl.waddr = pos_q[IW-1:0];
			ctl.wdata.b = nb_q;
			ctl.wdata.t = nt_q;
		end else if (state_q == ST_SHIFT && rv_q) begin
			ctl.we = 1'b1;
			ctl.waddr = wi_q[IW-1:0];
			ctl.wdata = rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= '0;
			ov_q <= 1'b0;
			rv_q <= 1'b0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						op_q <= op; s_q <= range_start; e_q <= e_in;
						ri_q <= '0; rv_q <= 1'b0;
						k_q <= '0; lo_q <= n_q; hi_q <= '0;
						pieces_q <= '0; cur_q <= {1'b0, range_start}; brk_q <= 1'b0;
						cov_q <= 1'b0; nxt_q <= range_start;
						pos_q <= n_q; fpos_q <= 1'b0;
						ps_q <= '0; pl_q <= '0; cv_q <= 1'b0; np_q <= '0; last_q <= 1'b1;
						if (op == OP_RSVD || (op == OP_ADD && e_in[32])) begin
							kind_q <= KIND_REJECT; state_q <= ST_WAIT;
						end else if (op == OP_ADD && range_length == 32'd0) begin
							kind_q <= KIND_NONE; state_q <= ST_WAIT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rv_q) begin
						if (op_q == OP_ADD) begin
							if (rt >= {1'b0, s_q} && rb <= e_q) begin
								if (k_q == '0) lo_q <= di_q;
								hi_q <= di_q; k_q <= k_q + 1'b1;
							end
							if (!fpos_q && !(rdata.b < s_q)) begin
								pos_q <= di_q; fpos_q <= 1'b1;
							end
							if (!brk_q) begin
								if (rb >= e_q) brk_q <= 1'b1;
								else if (rt > cur_q) begin
									if (rb > cur_q) pieces_q <= pieces_q + 1'b1;
									cur_q <= rt;
								end
							end
						end else if (op_q == OP_COV) begin
							if (rdata.b <= s_q && rt >= e_q) cov_q <= 1'b1;
						end else begin
							if (rdata.b <= s_q && s_q < rdata.t) nxt_q <= rdata.t;
						end
					end
					di_q <= ri_q;
					if (ri_q < n_eff) begin
						rv_q <= 1'b1; ri_q <= ri_q + 1'b1;
					end else if (rv_q) begin
						rv_q <= 1'b0;
					end else begin
						state_q <= (op_q == OP_ADD) ? ST_DEC : ST_WAIT;
						kind_q <= KIND_ANSWER;
						cv_q <= (op_q == OP_COV) && cov_q && !e_q[32];
						np_q <= (op_q == OP_NEXT) ? nxt_q : 32'd0;
					end
				end
				ST_DEC: begin
					if (cur_q < e_q) pieces_q <= pieces_q + 1'b1;
					if (pieces_q == '0 && !(cur_q < e_q)) begin
						kind_q <= KIND_NONE; state_q <= ST_WAIT;
					end else if (newn > (CW+1)'(MAX_INTERVALS)) begin
						kind_q <= KIND_REJECT; state_q <= ST_WAIT;
					end else begin
						nb_q <= s_q; nt_q <= e_q[31:0];
						cur_q <= {1'b0, s_q}; brk_q <= 1'b0; p_q <= '0;
						ri_q <= '0; rv_q <= 1'b0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// one entry at a time: read it, then handle it before the next read; hold while the output is busy
					if (rv_q) begin
						if (brk_q || rb >= e_q || rt <= cur_q) begin
							if (rb >= e_q) brk_q <= 1'b1;
							rv_q <= 1'b0;
						end else if (rb > cur_q) begin
							if (out_free) begin
								ov_q <= 1'b1; kind_q <= KIND_PIECE;
								ps_q <= cur_q[31:0]; pl_q <= rdata.b - cur_q[31:0];
								last_q <= (p_q + 1'b1 == pieces_q);
								p_q <= p_q + 1'b1; cur_q <= rt; rv_q <= 1'b0;
							end
						end else begin
							cur_q <= rt; rv_q <= 1'b0;
						end
						if (di_q == lo_q && k_q != '0) nb_q <= (rdata.b < s_q) ? rdata.b : s_q;
						if (di_q == hi_q && k_q != '0 && rt > e_q) nt_q <= rdata.t;
					end else if (ri_q < n_eff) begin
						di_q <= ri_q; rv_q <= 1'b1; ri_q <= ri_q + 1'b1;
					end else begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					if (out_free) begin
						if (cur_q < e_q) begin
							ov_q <= 1'b1; kind_q <= KIND_PIECE;
							ps_q <= cur_q[31:0]; pl_q <= e_q[31:0] - cur_q[31:0];
							last_q <= 1'b1;
						end
						if (k_q != '0) begin
							pos_q <= lo_q; wi_q <= lo_q + 1'b1; ri_q <= hi_q + 1'b1;
						end else begin
							// move entries up from the top down
							wi_q <= n_q; ri_q <= n_q - 1'b1;
						end
						rv_q <= 1'b0;
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (k_q != '0) begin
						if (rv_q) wi_q <= wi_q + 1'b1;
						if (ri_q < n_q && !rv_q) begin
							rv_q <= 1'b1; ri_q <= ri_q + 1'b1;
						end else if (rv_q) begin
							rv_q <= 1'b0;
						end else begin
							state_q <= ST_PUT;
						end
					end else begin
						if (rv_q) wi_q <= wi_q - 1'b1;
						if (wi_q > pos_q && !rv_q) begin
							rv_q <= 1'b1;
						end else if (rv_q) begin
							rv_q <= 1'b0; ri_q <= ri_q - 1'b1;
						end else begin
							state_q <= ST_PUT;
						end
					end
				end
				ST_PUT: begin
					n_q <= newn[CW-1:0];
					state_q <= ST_IDLE;
				end
				ST_WAIT: begin
					if (out_free) begin
						ov_q <= 1'b1; last_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign kind = kind_q;
	assign piece_start = (kind_q == KIND_PIECE) ? ps_q : 32'd0;
	assign piece_length = (kind_q == KIND_PIECE) ? pl_q : 32'd0;
	assign covered = (kind_q == KIND_ANSWER) ? cv_q : 1'b0;
	assign next_position = (kind_q == KIND_ANSWER) ? np_q : 32'd0;
	assign last = last_q;

	// checks
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(MAX_INTERVALS)) else $error("entry count overflow");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind))
		else $error("result dropped");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("accept while busy");
endmodule

/* design/isct_ram.sv */
module isct_ram import isct_pkg::*; (
	input  logic     clk,
	input  ram_ctl_t ctl,
	output entry_t   rdata
);
	entry_t mem [MAX_INTERVALS];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		rdata <= mem[ctl.raddr];
	end
endmodule
